FILE: src/fpp_pkg.sv
`timescale 1ns / 1ps
package fpp_pkg;
   localparam logic [31:0] SCALE_2B = 32'd32767;
   localparam logic [31:0] SCALE_3B = 32'd8388607;
   localparam logic [31:0] SCALE_4B = 32'd2147483520;
   localparam logic [2:0]  WIDTH_2B = 3'd2;
   localparam logic [2:0]  WIDTH_3B = 3'd3;
   localparam logic [2:0]  WIDTH_4B = 3'd4;
   localparam logic [7:0]  EXP_MAX  = 8'hFF;
   localparam logic [7:0]  EXP_ONE  = 8'd127;
   localparam logic [7:0]  EXP_BIAS_SHIFT = 8'd150;

   typedef enum logic [1:0] {
      KIND_ZERO = 2'd0,
      KIND_FULL = 2'd1,
      KIND_MUL  = 2'd2
   } kind_type;
endpackage

FILE: src/float_to_pcm_packer.sv
`timescale 1ns / 1ps
// Float32 to PCM packer. One sample transfer is accepted per clock unless the
// pipeline stalls; samples pass the classify, 24x32 multiply, round to 24
// significant bits and shift and pack stages in order. Stalls on rsp_tready
// hold the whole pipeline, so throughput is one sample per cycle while the
// sink is ready. Width register at address 0: 2, 3 or any other value for 4
// bytes; write it only while the pipeline is empty. NaN gives +full scale.
module float_to_pcm_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // sample_bits
   input  logic        req_tlast,   // end_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // packed_bytes[31:0], byte_count[34:32], zero
   output logic        rsp_tlast,   // last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [1:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   logic [2:0] bps_ff;
   logic       adv;
   logic [2:0] nb;
   logic [31:0] k;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == 2'd0) ? {29'd0, bps_ff} : 32'd0;
   always_ff @(posedge clock) begin
      if (reset) bps_ff <= fpp_pkg::WIDTH_2B;
      else if (csr_psel && csr_penable && csr_pwrite && csr_paddr == 2'd0)
         bps_ff <= csr_pwdata[2:0];
   end

   always_comb begin
      case (bps_ff)
         fpp_pkg::WIDTH_2B: begin nb = fpp_pkg::WIDTH_2B; k = fpp_pkg::SCALE_2B; end
         fpp_pkg::WIDTH_3B: begin nb = fpp_pkg::WIDTH_3B; k = fpp_pkg::SCALE_3B; end
         default:           begin nb = fpp_pkg::WIDTH_4B; k = fpp_pkg::SCALE_4B; end
      endcase
   end

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   assign adv = !v4_ff || rsp_tready;
   assign req_tready = adv;

   // stage 1: classify
   fpp_pkg::kind_type kind1_ff;
   logic        sign1_ff, last1_ff;
   logic [7:0]  exp1_ff;
   logic [23:0] man1_ff;
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_tvalid;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         sign1_ff <= req_tdata[31];
         exp1_ff  <= req_tdata[30:23];
         man1_ff  <= {1'b1, req_tdata[22:0]};
         last1_ff <= req_tlast;
         if (req_tdata[30:23] == fpp_pkg::EXP_MAX && req_tdata[22:0] != 23'd0) begin
            kind1_ff <= fpp_pkg::KIND_FULL;
            sign1_ff <= 1'b0;
         end else if (req_tdata[30:23] >= fpp_pkg::EXP_ONE) kind1_ff <= fpp_pkg::KIND_FULL;
         else if (req_tdata[30:23] == 8'd0) kind1_ff <= fpp_pkg::KIND_ZERO;
         else kind1_ff <= fpp_pkg::KIND_MUL;
      end
   end

   // stage 2: multiply
   fpp_pkg::kind_type kind2_ff;
   logic        sign2_ff, last2_ff;
   logic [7:0]  exp2_ff;
   logic [55:0] prod2_ff;
   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         kind2_ff <= kind1_ff; sign2_ff <= sign1_ff; last2_ff <= last1_ff;
         exp2_ff  <= exp1_ff;
         prod2_ff <= {32'd0, man1_ff} * {24'd0, k};
      end
   end

   // stage 3: round to 24 significant bits (product has 38..39, 46..47 or 54..55 bits)
   logic [5:0]  r;
   logic [55:0] q, rem, half, rnd_in;
   always_comb begin
      case (nb)
         fpp_pkg::WIDTH_2B: r = prod2_ff[38] ? 6'd15 : 6'd14;
         fpp_pkg::WIDTH_3B: r = prod2_ff[46] ? 6'd23 : 6'd22;
         default:           r = prod2_ff[54] ? 6'd31 : 6'd30;
      endcase
      q    = prod2_ff >> r;
      rem  = prod2_ff & ((56'd1 << r) - 56'd1);
      half = 56'd1 << (r - 6'd1);
      if (rem > half || (rem == half && q[0])) q = q + 56'd1;
      rnd_in = q << r;
   end
   fpp_pkg::kind_type kind3_ff;
   logic        sign3_ff, last3_ff;
   logic [7:0]  exp3_ff;
   logic [55:0] p3_ff;
   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         kind3_ff <= kind2_ff; sign3_ff <= sign2_ff; last3_ff <= last2_ff;
         exp3_ff <= exp2_ff;
         p3_ff <= rnd_in;
      end
   end

   // stage 4: shift, sign and pack
   logic [7:0]  sh;
   logic [31:0] mag, v, mask;
   always_comb begin
      sh = fpp_pkg::EXP_BIAS_SHIFT - exp3_ff;
      case (kind3_ff)
         fpp_pkg::KIND_FULL: mag = k;
         fpp_pkg::KIND_MUL: begin
            if (sh >= 8'd64) mag = 32'd0;
            else mag = 32'(p3_ff >> sh[5:0]);
         end
         default: mag = 32'd0;
      endcase
      v = sign3_ff ? (32'd0 - mag) : mag;
      case (nb)
         fpp_pkg::WIDTH_2B: mask = 32'h0000FFFF;
         fpp_pkg::WIDTH_3B: mask = 32'h00FFFFFF;
         default:           mask = 32'hFFFFFFFF;
      endcase
   end
   logic [31:0] out4_ff;
   logic [2:0]  nb4_ff;
   logic        last4_ff;
   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (adv) v4_ff <= v3_ff;
   end
   always_ff @(posedge clock) begin
      if (adv) begin
         out4_ff <= v & mask; nb4_ff <= nb; last4_ff <= last3_ff;
      end
   end
   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {5'd0, nb4_ff, out4_ff};
   assign rsp_tlast  = last4_ff;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (nb4_ff == fpp_pkg::WIDTH_2B || nb4_ff == fpp_pkg::WIDTH_3B ||
                      nb4_ff == fpp_pkg::WIDTH_4B))
      else $error("bad byte count");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      adv && v3_ff |=> v4_ff)
      else $error("item lost");
endmodule

FILE: bench/tb_float_to_pcm_packer.sv
`timescale 1ns / 1ps
module tb_float_to_pcm_packer;

   typedef struct packed {
      logic [31:0] bits;
      logic        eob;
   } sample_type;

   typedef struct packed {
      logic [31:0] packed_bytes;
      logic [2:0]  byte_count;
      logic        last;
   } pcm_type;

   localparam logic [1:0] ADDR_WIDTH_REG = 2'd0;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [1:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   float_to_pcm_packer u_dut (.*);

   sample_type  sample_q[$];
   pcm_type     pcm_q[$];
   logic [2:0]  width_reg;
   int          errors;
   int          src_idle_pct;
   int          snk_idle_pct;
   bit          hold_sink;
   int          hold_cycles;
   bit          hold_active;
   logic        req_tready_s;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic logic [31:0] scale_for(input logic [2:0] w);
      if (w == fpp_pkg::WIDTH_2B) return fpp_pkg::SCALE_2B;
      if (w == fpp_pkg::WIDTH_3B) return fpp_pkg::SCALE_3B;
      return fpp_pkg::SCALE_4B;
   endfunction

   function automatic pcm_type convert_sample(input sample_type s, input logic [2:0] w);
      pcm_type     r;
      logic        sgn;
      logic [7:0]  ex;
      logic [22:0] fr;
      logic [31:0] k;
      logic [31:0] mag;
      logic [31:0] v;
      logic [2:0]  nb;
      logic [63:0] p;
      logic [63:0] q;
      logic [63:0] rem;
      logic [63:0] half;
      int          n;
      int          sh;
      sgn = s.bits[31];
      ex  = s.bits[30:23];
      fr  = s.bits[22:0];
      nb  = (w == fpp_pkg::WIDTH_2B) ? 3'd2 : (w == fpp_pkg::WIDTH_3B) ? 3'd3 : 3'd4;
      k   = scale_for(w);
      if (ex == fpp_pkg::EXP_MAX && fr != 0) begin
         sgn = 1'b0;
         mag = k;
      end else if (ex >= fpp_pkg::EXP_ONE) begin
         mag = k;
      end else if (ex == 0) begin
         mag = 0;
      end else begin
         p = {40'd0, 1'b1, fr} * {32'd0, k};
         n = 0;
         for (int i = 0; i < 64; i++) if (p[i]) n = i + 1;
         if (n > 24) begin
            q    = p >> (n - 24);
            rem  = p & ((64'd1 << (n - 24)) - 1);
            half = 64'd1 << (n - 25);
            if (rem > half || (rem == half && q[0])) q++;
            p = q << (n - 24);
         end
         sh  = 150 - ex;
         mag = (sh >= 64) ? 32'd0 : 32'(p >> sh);
      end
      v = sgn ? (32'd0 - mag) : mag;
      if (nb == 3'd2) v[31:16] = '0;
      else if (nb == 3'd3) v[31:24] = '0;
      r.packed_bytes = v;
      r.byte_count   = nb;
      r.last         = s.eob;
      return r;
   endfunction

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready_s) begin
         if (sample_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= sample_q[0].bits;
            req_tlast  <= sample_q[0].eob;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // accept flag captured at posedge so the driver never races the DUT
   always @(posedge clock) begin
      req_tready_s <= !reset && req_tvalid && req_tready;
      if (!reset && req_tvalid && req_tready) begin
         pcm_q.push_back(convert_sample(sample_q.pop_front(), width_reg));
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready  <= 1'b0;
         hold_active <= 1'b0;
      end else if (hold_sink && !hold_active) begin
         hold_active <= 1'b1;
         hold_cycles <= 300;
         rsp_tready  <= 1'b0;
      end else if (hold_active && hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready  <= 1'b0;
      end else begin
         if (!hold_sink) hold_active <= 1'b0;
         rsp_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
   end

   // monitor
   always @(posedge clock) begin
      pcm_type got;
      pcm_type exp_r;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.packed_bytes = rsp_tdata[31:0];
         got.byte_count   = rsp_tdata[34:32];
         got.last         = rsp_tlast;
         if (pcm_q.size() == 0) begin
            $error("unexpected transfer: packed_bytes %h", got.packed_bytes);
            errors++;
         end else begin
            exp_r = pcm_q.pop_front();
            if (got.packed_bytes !== exp_r.packed_bytes) begin
               $error("packed_bytes expected %h actual %h",
                      exp_r.packed_bytes, got.packed_bytes);
               errors++;
            end
            if (got.byte_count !== exp_r.byte_count) begin
               $error("byte_count expected %0d actual %0d",
                      exp_r.byte_count, got.byte_count);
               errors++;
            end
            if (got.last !== exp_r.last) begin
               $error("last expected %0d actual %0d", exp_r.last, got.last);
               errors++;
            end
            if (rsp_tdata[39:35] !== 5'd0) begin
               $error("tdata pad expected 0 actual %h", rsp_tdata[39:35]);
               errors++;
            end
         end
      end
   end

   task automatic wait_drained();
      while (sample_q.size() != 0 || pcm_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_width(input logic [2:0] w);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ADDR_WIDTH_REG;
      csr_pwdata  <= {$urandom} & 32'hFFFF_FFF8 | 32'(w);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      width_reg = w;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   function automatic logic [31:0] rand_sample();
      logic [31:0] b;
      b = $urandom;
      case ($urandom_range(9))
         0: b[30:23] = 8'hFF;
         1: b[30:23] = 8'h00;
         2: b[30:23] = 8'd126;
         3: b[30:23] = 8'd127;
         4, 5, 6, 7, 8: b[30:23] = 8'($urandom_range(126, 95));
         default: ;
      endcase
      return b;
   endfunction

   task automatic queue_sample(input logic [31:0] b);
      sample_type s;
      s.bits = b;
      s.eob  = ($urandom_range(7) == 0);
      sample_q.push_back(s);
   endtask

   logic [31:0] corner_bits[] = '{
      32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF,
      32'h3F80_0000, 32'hBF80_0000, 32'h7F80_0000, 32'hFF80_0000,
      32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h3F7F_FFFF,
      32'hBF7F_FFFF, 32'h3F00_0000, 32'hBF00_0000, 32'h0080_0000,
      32'h3380_0000, 32'h4000_0000, 32'h7F7F_FFFF, 32'h3E80_0001
   };

   logic [2:0] width_plan[] = '{3'd3, 3'd4, 3'd0, 3'd7, 3'd2, 3'd5};

   initial begin
      errors       = 0;
      width_reg    = fpp_pkg::WIDTH_2B;
      src_idle_pct = 27;
      snk_idle_pct = 27;
      hold_sink    = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      rsp_tready   = 1'b0;
      csr_psel     = 1'b0;
      csr_penable  = 1'b0;
      csr_pwrite   = 1'b0;
      csr_paddr    = '0;
      csr_pwdata   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all directed corners at reset width, then a quarter of them plus random samples per planned width
      foreach (corner_bits[i]) queue_sample(corner_bits[i]);
      wait_drained();
      foreach (width_plan[w]) begin
         write_width(width_plan[w]);
         foreach (corner_bits[i]) if (i % 4 == w % 4) queue_sample(corner_bits[i]);
         for (int i = 0; i < 60; i++) queue_sample(rand_sample());
         if (w == 1) begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
         end else if (w == 2) begin
            src_idle_pct = 27;
            snk_idle_pct = 27;
            hold_sink    = 1'b1;
            while (sample_q.size() > 30) @(posedge clock);
            hold_sink    = 1'b0;
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
